### design/polygon_prism_query_assert.svh
// Assertion macros of the polygon prism query design, used by the controller
`ifndef POLYGON_PRISM_QUERY_ASSERT_SVH
`define POLYGON_PRISM_QUERY_ASSERT_SVH
// Assert an implication on every clock edge outside reset
`define PPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert an implication in the cycle after the antecedent
`define PPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/ppq_pkg.sv
// Package: types and constants of the polygon prism query block
`default_nettype none
package ppq_pkg;
	localparam int MaxVertices = 256;
	localparam int CoordWidth = 16;
	localparam int AddrWidth = $clog2(MaxVertices);
	localparam int CountWidth = AddrWidth + 1;
	localparam int VolWidth = 49;
	localparam int AccWidth = 2 * CoordWidth + AddrWidth + 3;
	localparam int HdWidth = 15;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_CLEAR = 2'd0;
	localparam cmd_t CMD_APPEND = 2'd1;
	localparam cmd_t CMD_QUERY = 2'd2;
	localparam cmd_t CMD_REPORT = 2'd3;

	typedef logic [1:0] stat_t;
	localparam stat_t ST_OK = 2'd0;
	localparam stat_t ST_INCOMPLETE = 2'd1;
	localparam stat_t ST_FULL = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic latch_in;    // take the command beat
		logic clear_cnt;   // empty the table
		logic append;      // write a vertex
		logic rd_issue;    // read entry rd_addr
		logic [AddrWidth-1:0] rd_addr;
		logic first;       // read data is vertex 0 (seed)
		logic edge_go;     // read data is a new vertex, process edge
		logic close;       // process closing edge (last to vertex 0)
		logic vol_go;      // start volume scaling
		logic done;        // drive a result beat
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic [CountWidth-1:0] count;
		logic vol_busy;
	} sts_t;
endpackage
`default_nettype wire

### design/polygon_prism_query.sv
// Top level of the polygon prism query block
// Channel | Handshake        | Payload
// command | start / busy     | command, x_coord, y_coord, z_coord
// config  | cfg_valid/ready  | cfg_data (half_depth)
// result  | done strobe      | inside_res, volume, box, z_min, z_max, status
// Query and report walk the table once, one vertex a cycle through the table read
// port; report adds shift-add scaling for the volume.
// Reset is asynchronous; the table empties at once (count cleared).
// Busy is high from the accepted beat until the result strobe; results never stall.
`default_nettype none
module polygon_prism_query (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         command,
	input  wire logic signed [15:0] x_coord,
	input  wire logic signed [15:0] y_coord,
	input  wire logic signed [15:0] z_coord,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [14:0]        cfg_data,
	output logic                    done,
	output logic                    inside_res,
	output logic [48:0]             volume,
	output logic signed [15:0]      x_min,
	output logic signed [15:0]      x_max,
	output logic signed [15:0]      y_min,
	output logic signed [15:0]      y_max,
	output logic signed [15:0]      z_min,
	output logic [14:0]             z_max,
	output logic [1:0]              status
);
	import ppq_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic [HdWidth-1:0] half_depth_q;

	// Hold the half depth register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) half_depth_q <= '0;
		else if (cfg_valid) half_depth_q <= cfg_data;
	end

	ppq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
	);

	ppq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .half_depth(half_depth_q),
		.command(command), .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.done(done), .inside_res(inside_res), .volume(volume),
		.x_min(x_min), .x_max(x_max), .y_min(y_min), .y_max(y_max),
		.z_min(z_min), .z_max(z_max), .status(status)
	);
endmodule
`default_nettype wire

### design/ppq_ctrl.sv
// Controller state machine of the polygon prism query block
`default_nettype none
`include "polygon_prism_query_assert.svh"
module ppq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ppq_pkg::sts_t sts,
	output ppq_pkg::ctl_t      ctl
);
	import ppq_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_READ  = 7'b0000100,
		S_EDGE  = 7'b0001000,
		S_CLOSE = 7'b0010000,
		S_VOL   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CountWidth-1:0] idx_q;     // next entry to read
	logic pend_q;                      // read data arrives this cycle
	logic [1:0] tail_q;                // drain of the edge pipeline

	wire last_rd = (idx_q == sts.count);

	always_comb begin
		ctl = '0;
		ctl.latch_in = (state_q == S_IDLE) && start;
		ctl.rd_addr = idx_q[AddrWidth-1:0];
		ctl.first = (state_q == S_READ) && pend_q && (idx_q == CountWidth'(1));
		ctl.edge_go = (state_q == S_READ) && pend_q && (idx_q != CountWidth'(1));
		ctl.rd_issue = (state_q == S_READ) && !last_rd;
		ctl.close = (state_q == S_CLOSE) && (tail_q == 2'd3);
		ctl.clear_cnt = (state_q == S_DEC) && (sts.cmd == CMD_CLEAR);
		ctl.append = (state_q == S_DEC) && (sts.cmd == CMD_APPEND);
		ctl.vol_go = (state_q == S_CLOSE) && (tail_q == 2'd0)
			&& (sts.cmd == CMD_REPORT);
		ctl.done = (state_q == S_DONE);
	end

	assign busy = (state_q != S_IDLE);

	// Sequence: decode; for query and report walk the table and close the polygon; scale for report; result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			pend_q <= 1'b0;
			tail_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DEC;
				end
				S_DEC: begin
					idx_q <= '0;
					pend_q <= 1'b0;
					if (sts.cmd == CMD_CLEAR || sts.cmd == CMD_APPEND
						|| sts.count < CountWidth'(3))
						state_q <= S_DONE;
					else
						state_q <= S_READ;
				end
				S_READ: begin
					pend_q <= !last_rd;
					if (!last_rd) idx_q <= idx_q + 1'b1;
					else begin
						state_q <= S_CLOSE;
						tail_q <= 2'd3;
					end
				end
				S_CLOSE: begin
					if (tail_q != 2'd0) tail_q <= tail_q - 1'b1;
					else state_q <= (sts.cmd == CMD_REPORT) ? S_VOL : S_DONE;
				end
				S_VOL: begin
					if (!sts.vol_busy) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PPQ_ASSERT_IMPL(a_read_in_range, clk, arst_n, ctl.rd_issue, idx_q < sts.count, "read beyond table")
	`PPQ_ASSERT_NEXT(a_done_idle, clk, arst_n, ctl.done, !busy, "no return to idle after result")
	`PPQ_ASSERT_NEXT(a_start_busy, clk, arst_n, (!busy && start), busy, "accepted beat did not raise busy")
endmodule
`default_nettype wire

### design/ppq_datapath.sv
// Datapath: vertex table, crossing test, shoelace sum, box and volume scaling
`default_nettype none
module ppq_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ppq_pkg::ctl_t        ctl,
	output ppq_pkg::sts_t             sts,
	input  wire logic [ppq_pkg::HdWidth-1:0] half_depth,
	input  wire logic [1:0]           command,
	input  wire logic signed [15:0]   x_coord,
	input  wire logic signed [15:0]   y_coord,
	input  wire logic signed [15:0]   z_coord,
	output logic                      done,
	output logic                      inside_res,
	output logic [48:0]               volume,
	output logic signed [15:0]        x_min,
	output logic signed [15:0]        x_max,
	output logic signed [15:0]        y_min,
	output logic signed [15:0]        y_max,
	output logic signed [15:0]        z_min,
	output logic [14:0]               z_max,
	output logic [1:0]                status
);
	import ppq_pkg::*;

	localparam int CW = CoordWidth;
	localparam int DW = CW + 1;          // difference width
	localparam int PW = 2 * DW;          // product width

	// Vertex table
	logic signed [CW-1:0] mem_x [MaxVertices];
	logic signed [CW-1:0] mem_y [MaxVertices];
	logic signed [CW-1:0] rx_q, ry_q;
	logic [CountWidth-1:0] count_q;
	logic full_q;

	// Command beat
	cmd_t cmd_q;
	logic signed [CW-1:0] px_q, py_q, pz_q;

	// Walk registers
	logic signed [CW-1:0] x0_q, y0_q, xp_q, yp_q, xmn_q, xmx_q, ymn_q, ymx_q;
	logic in_q, zok_q;
	logic signed [AccWidth-1:0] acc_q;

	// Edge stage registers
	logic v1_s1;
	logic signed [DW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic dpos_s1;
	logic signed [PW-1:0] lhs_s2, rhs_s2, sh1_s2, sh2_s2;
	logic v_s2, dpos_s2;
	logic signed [PW-1:0] sa_s1, sb_s1;

	// Volume scaling
	logic [VolWidth-1:0] vol_q;
	logic vol_busy_q;
	logic [3:0] vstep_q;
	logic [AccWidth-1:0] mag_q;

	assign sts.cmd = cmd_q;
	assign sts.count = count_q;
	assign sts.vol_busy = vol_busy_q;

	// Latch the command beat
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			cmd_q <= command;
			px_q <= x_coord;
			py_q <= y_coord;
			pz_q <= z_coord;
		end
	end

	// Write and read the table; note a rejected append
	always_ff @(posedge clk) begin
		if (ctl.append) full_q <= (count_q == CountWidth'(MaxVertices));
		if (ctl.append && count_q < CountWidth'(MaxVertices)) begin
			mem_x[count_q[AddrWidth-1:0]] <= px_q;
			mem_y[count_q[AddrWidth-1:0]] <= py_q;
		end
		if (ctl.rd_issue) begin
			rx_q <= mem_x[ctl.rd_addr];
			ry_q <= mem_y[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (ctl.clear_cnt) count_q <= '0;
		else if (ctl.append && count_q < CountWidth'(MaxVertices))
			count_q <= count_q + 1'b1;
	end

	// Edge operands: current vertex i and previous vertex k
	logic signed [CW-1:0] ex_i, ey_i, ex_k, ey_k;
	logic ev;
	always_comb begin
		ev = ctl.edge_go || ctl.close;
		ex_i = ctl.close ? x0_q : rx_q;
		ey_i = ctl.close ? y0_q : ry_q;
		ex_k = xp_q;
		ey_k = yp_q;
	end

	// Stage 1: crossing check and differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v1_s1 <= ev && ((ey_i > py_q) != (ey_k > py_q));
			v_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		a1_s1 <= DW'(px_q) - DW'(ex_i);
		b1_s1 <= DW'(ey_k) - DW'(ey_i);
		a2_s1 <= DW'(py_q) - DW'(ey_i);
		b2_s1 <= DW'(ex_k) - DW'(ex_i);
		dpos_s1 <= ey_k > ey_i;
		sa_s1 <= ev ? PW'(ex_k) * PW'(ey_i) : '0;
		sb_s1 <= ev ? PW'(ex_i) * PW'(ey_k) : '0;
		// Stage 2: products
		lhs_s2 <= PW'(a1_s1) * PW'(b1_s1);
		rhs_s2 <= PW'(a2_s1) * PW'(b2_s1);
		dpos_s2 <= dpos_s1;
		sh1_s2 <= sa_s1;
		sh2_s2 <= sb_s1;
	end

	// Accumulate crossing parity, shoelace sum and bounding box
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			in_q <= 1'b0;
			acc_q <= '0;
		end else begin
			if (v_s2 && (dpos_s2 ? (lhs_s2 < rhs_s2) : (rhs_s2 < lhs_s2)))
				in_q <= !in_q;
			acc_q <= acc_q + AccWidth'(sh1_s2) - AccWidth'(sh2_s2);
		end
		zok_q <= ((pz_q < 0) ? -DW'(pz_q) : DW'(pz_q)) <= DW'({1'b0, half_depth});
		if (ctl.first) begin
			x0_q <= rx_q; y0_q <= ry_q;
			xmn_q <= rx_q; xmx_q <= rx_q;
			ymn_q <= ry_q; ymx_q <= ry_q;
		end else if (ctl.edge_go) begin
			if (rx_q < xmn_q) xmn_q <= rx_q;
			if (rx_q > xmx_q) xmx_q <= rx_q;
			if (ry_q < ymn_q) ymn_q <= ry_q;
			if (ry_q > ymx_q) ymx_q <= ry_q;
		end
		if (ctl.first || ctl.edge_go) begin
			xp_q <= rx_q; yp_q <= ry_q;
		end
	end

	// Volume: |sum| * half_depth by shift-add, 15 steps, saturating at 2^48
	localparam logic [VolWidth-1:0] VolMax = VolWidth'(1) << (VolWidth - 1);
	logic [VolWidth+AccWidth:0] vtmp;
	always_comb begin
		vtmp = (VolWidth + AccWidth + 1)'(vol_q) << 1;
		if (half_depth[4'(HdWidth-1) - vstep_q])
			vtmp = vtmp + (VolWidth + AccWidth + 1)'(mag_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_busy_q <= 1'b0;
			vstep_q <= '0;
		end else if (ctl.vol_go) begin
			vol_busy_q <= 1'b1;
			vstep_q <= '0;
		end else if (vol_busy_q) begin
			if (vstep_q == 4'(HdWidth - 1)) vol_busy_q <= 1'b0;
			vstep_q <= vstep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vol_go) begin
			vol_q <= '0;
			mag_q <= acc_q[AccWidth-1] ? AccWidth'(-acc_q) : AccWidth'(acc_q);
		end else if (vol_busy_q) begin
			vol_q <= (vtmp > (VolWidth + AccWidth + 1)'(VolMax)) ? VolMax
				: vtmp[VolWidth-1:0];
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl.done;
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			inside_res <= 1'b0;
			volume <= '0;
			x_min <= '0; x_max <= '0; y_min <= '0; y_max <= '0;
			z_min <= '0; z_max <= '0;
			status <= ST_OK;
			case (cmd_q)
				CMD_CLEAR: status <= ST_OK;
				CMD_APPEND: begin
					if (full_q) status <= ST_FULL;
				end
				default: begin
					if (count_q < CountWidth'(3)) status <= ST_INCOMPLETE;
					else if (cmd_q == CMD_QUERY) inside_res <= in_q && zok_q;
					else begin
						volume <= vol_q;
						x_min <= xmn_q; x_max <= xmx_q;
						y_min <= ymn_q; y_max <= ymx_q;
						z_min <= -16'($unsigned(half_depth));
						z_max <= half_depth;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire
